// ===== src/hxm_pkg.sv =====
// Package for the hexacopter-X motor mixer: widths, fixed-point constants
// and the demand type shared by the mixer pipeline.
// No dependencies.
package hxm_pkg;

   localparam int MOTORS     = 6;
   localparam int CMD_W      = 13;   // signed command width
   localparam int PWM_W      = 11;   // unsigned pulse width output
   localparam int DEM_W      = 16;   // signed mixed demand
   localparam int PK_MAG_W   = 12;   // magnitude of cos30 * pitch

   // cos(30 deg) in Q0.16, nearest.
   localparam int COS30_Q16  = 56756;
   localparam int COS30_W    = 16;
   localparam int PK_PROD_W  = CMD_W + COS30_W;

   localparam int FULL_SCALE = 1000;
   localparam int PWM_MIN    = FULL_SCALE;
   localparam int PWM_MAX    = 2 * FULL_SCALE;

   // Restoring divider for FULL_SCALE^2 / max, two quotient bits per stage.
   localparam int DIVIDEND    = FULL_SCALE * FULL_SCALE;
   localparam int REM_W       = 20;
   localparam int DEN_W       = 14;
   localparam int QUO_W       = 10;
   localparam int DIV_SHIFT_W = REM_W + 4;
   localparam int DIV_STAGES  = QUO_W / 2;

   // Demand times scale, then saturated to 0..FULL_SCALE^2.
   localparam int PROD_W      = 26;
   localparam int SAT_W       = 20;
   localparam int SAT_MAX     = FULL_SCALE * FULL_SCALE;

   // floor(x / 1000) = (x * RECIP) >> RECIP_SHIFT, exact for x < 2^SAT_W.
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP       = 1073742;
   localparam int RECIP_W     = 21;
   localparam int RPROD_W     = SAT_W + RECIP_W;

   // Input register, mix, max, divider stages, multiply, saturate, output.
   localparam int LATENCY     = DIV_STAGES + 6;

   typedef logic signed [DEM_W-1:0] demand_type;

endpackage

// ===== src/hexacopter_x_motor_mixer.sv =====
// Hexacopter-X motor mixer: one pipelined module from command to pulse widths.
// Depends on hxm_pkg for widths, fixed-point constants and the demand type.
//
// A transaction is taken on every clock at which start is high and busy is low;
// busy is high only while reset is asserted, so the mixer accepts one command
// per cycle. Each command produces one set of six pulse widths at the pipeline end,
// shown for a single cycle with rsp_valid high. The receiver has no way to stall
// the output and must take each result in the cycle it appears.
// The largest part of the latency is the scale division 1000000 / max, done
// by a five-stage restoring divider retiring two quotient bits per stage; the
// rest is input registering, mixing, the maximum search, the scale multiply,
// saturation and the reciprocal multiply that divides by 1000.
module hexacopter_x_motor_mixer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [hxm_pkg::CMD_W-1:0] req_thrust_milli,
   input  logic signed [hxm_pkg::CMD_W-1:0] req_roll_milli,
   input  logic signed [hxm_pkg::CMD_W-1:0] req_pitch_milli,
   input  logic signed [hxm_pkg::CMD_W-1:0] req_yaw_milli,
   output logic                            rsp_valid,
   output logic        [hxm_pkg::PWM_W-1:0] rsp_motor_one_pwm,
   output logic        [hxm_pkg::PWM_W-1:0] rsp_motor_two_pwm,
   output logic        [hxm_pkg::PWM_W-1:0] rsp_motor_three_pwm,
   output logic        [hxm_pkg::PWM_W-1:0] rsp_motor_four_pwm,
   output logic        [hxm_pkg::PWM_W-1:0] rsp_motor_five_pwm,
   output logic        [hxm_pkg::PWM_W-1:0] rsp_motor_six_pwm
);

   localparam int MOTORS     = hxm_pkg::MOTORS;
   localparam int DIV_STAGES = hxm_pkg::DIV_STAGES;

   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   // ---------------------------------------------------------------------
   // Stage 1: register commands, half roll and cos30 * |pitch|.
   // ---------------------------------------------------------------------
   logic                               s1_valid_ff;
   logic signed [hxm_pkg::CMD_W-1:0]   s1_thrust_ff, s1_roll_ff, s1_yaw_ff, s1_half_ff;
   logic        [hxm_pkg::PK_MAG_W-1:0] s1_pk_mag_ff;
   logic                               s1_pk_neg_ff;

   logic signed [hxm_pkg::CMD_W:0]     roll_adj;
   logic signed [hxm_pkg::CMD_W-1:0]   s1_half_in;
   logic        [hxm_pkg::CMD_W-1:0]   pitch_mag;
   logic        [hxm_pkg::PK_PROD_W-1:0] pk_prod;

   // Adding one to negative values before the arithmetic shift rounds toward zero.
   assign roll_adj   = (hxm_pkg::CMD_W+1)'(req_roll_milli)
                     + (hxm_pkg::CMD_W+1)'(req_roll_milli[hxm_pkg::CMD_W-1]);
   assign s1_half_in = hxm_pkg::CMD_W'(roll_adj >>> 1);
   assign pitch_mag  = req_pitch_milli[hxm_pkg::CMD_W-1] ? hxm_pkg::CMD_W'(-req_pitch_milli)
                                                         : hxm_pkg::CMD_W'(req_pitch_milli);
   assign pk_prod    = hxm_pkg::PK_PROD_W'(pitch_mag)
                     * hxm_pkg::PK_PROD_W'(hxm_pkg::COS30_Q16);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_thrust_ff <= req_thrust_milli;
      s1_roll_ff   <= req_roll_milli;
      s1_yaw_ff    <= req_yaw_milli;
      s1_half_ff   <= s1_half_in;
      s1_pk_mag_ff <= pk_prod[hxm_pkg::COS30_W +: hxm_pkg::PK_MAG_W];
      s1_pk_neg_ff <= req_pitch_milli[hxm_pkg::CMD_W-1];
   end

   // ---------------------------------------------------------------------
   // Stage 2: mixing table.
   // ---------------------------------------------------------------------
   logic                s2_valid_ff;
   logic                s2_tpos_ff;
   hxm_pkg::demand_type s2_dem_ff [MOTORS];
   hxm_pkg::demand_type s2_dem_in [MOTORS];
   hxm_pkg::demand_type t16, r16, y16, rh16, pk16, pk_pos;
   logic                s2_tpos_in;

   assign t16    = hxm_pkg::DEM_W'(s1_thrust_ff);
   assign r16    = hxm_pkg::DEM_W'(s1_roll_ff);
   assign y16    = hxm_pkg::DEM_W'(s1_yaw_ff);
   assign rh16   = hxm_pkg::DEM_W'(s1_half_ff);
   assign pk_pos = hxm_pkg::DEM_W'(s1_pk_mag_ff);
   assign pk16   = s1_pk_neg_ff ? -pk_pos : pk_pos;

   assign s2_dem_in[0] = t16 - r16 + y16;
   assign s2_dem_in[1] = t16 + r16 - y16;
   assign s2_dem_in[2] = t16 + rh16 - pk16 + y16;
   assign s2_dem_in[3] = t16 - rh16 + pk16 - y16;
   assign s2_dem_in[4] = t16 - rh16 - pk16 - y16;
   assign s2_dem_in[5] = t16 + rh16 + pk16 + y16;
   assign s2_tpos_in   = !s1_thrust_ff[hxm_pkg::CMD_W-1] && (s1_thrust_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_tpos_ff <= s2_tpos_in;
      s2_dem_ff  <= s2_dem_in;
   end

   // ---------------------------------------------------------------------
   // Stage 3: largest demand with a floor of full scale; this register
   // also heads the divider.
   // ---------------------------------------------------------------------
   logic                      div_valid_ff [DIV_STAGES+1];
   logic                      div_tpos_ff  [DIV_STAGES+1];
   logic [hxm_pkg::DEN_W-1:0] div_den_ff   [DIV_STAGES+1];
   hxm_pkg::demand_type       div_dem_ff   [DIV_STAGES+1][MOTORS];
   logic [hxm_pkg::REM_W-1:0] div_rem_ff   [1:DIV_STAGES];
   logic [hxm_pkg::QUO_W-1:0] div_quo_ff   [1:DIV_STAGES];

   hxm_pkg::demand_type       max_dem;
   logic [hxm_pkg::DEN_W-1:0] div_den_in;

   always_comb begin
      max_dem = hxm_pkg::DEM_W'(hxm_pkg::FULL_SCALE);
      for (int i = 0; i < MOTORS; i++) begin
         if (s2_dem_ff[i] > max_dem) begin
            max_dem = s2_dem_ff[i];
         end
      end
   end

   assign div_den_in = hxm_pkg::DEN_W'(max_dem);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff[0] <= 1'b0;
      end else begin
         div_valid_ff[0] <= s2_valid_ff;
      end
      div_tpos_ff[0] <= s2_tpos_ff;
      div_den_ff[0]  <= div_den_in;
      div_dem_ff[0]  <= s2_dem_ff;
   end

   // ---------------------------------------------------------------------
   // Divider stages: restoring division of FULL_SCALE^2 by the maximum,
   // two quotient bits per stage, most significant first.
   // ---------------------------------------------------------------------
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      localparam int BIT_HI = hxm_pkg::QUO_W - 1 - 2 * s;
      localparam int BIT_LO = hxm_pkg::QUO_W - 2 - 2 * s;

      logic [hxm_pkg::REM_W-1:0]       rem_src, rem_mid, rem_in;
      logic [hxm_pkg::QUO_W-1:0]       quo_src, quo_in;
      logic [hxm_pkg::DIV_SHIFT_W-1:0] den_hi, den_lo, rem_src_ext, rem_mid_ext;
      logic                            ge_hi, ge_lo;

      if (s == 0) begin : g_first
         assign rem_src = hxm_pkg::REM_W'(hxm_pkg::DIVIDEND);
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = div_rem_ff[s];
         assign quo_src = div_quo_ff[s];
      end

      assign den_hi      = hxm_pkg::DIV_SHIFT_W'(div_den_ff[s]) << BIT_HI;
      assign den_lo      = hxm_pkg::DIV_SHIFT_W'(div_den_ff[s]) << BIT_LO;
      assign rem_src_ext = hxm_pkg::DIV_SHIFT_W'(rem_src);
      assign ge_hi       = rem_src_ext >= den_hi;
      assign rem_mid     = ge_hi ? hxm_pkg::REM_W'(rem_src_ext - den_hi) : rem_src;
      assign rem_mid_ext = hxm_pkg::DIV_SHIFT_W'(rem_mid);
      assign ge_lo       = rem_mid_ext >= den_lo;
      assign rem_in      = ge_lo ? hxm_pkg::REM_W'(rem_mid_ext - den_lo) : rem_mid;
      assign quo_in      = quo_src | (hxm_pkg::QUO_W'({ge_hi, ge_lo}) << BIT_LO);

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[s+1] <= 1'b0;
         end else begin
            div_valid_ff[s+1] <= div_valid_ff[s];
         end
         div_tpos_ff[s+1] <= div_tpos_ff[s];
         div_den_ff[s+1]  <= div_den_ff[s];
         div_dem_ff[s+1]  <= div_dem_ff[s];
         div_rem_ff[s+1]  <= rem_in;
         div_quo_ff[s+1]  <= quo_in;
      end
   end

   // ---------------------------------------------------------------------
   // Scale multiply: demand times quotient.
   // ---------------------------------------------------------------------
   logic                             mul_valid_ff, mul_tpos_ff;
   logic signed [hxm_pkg::PROD_W-1:0] mul_prod_ff [MOTORS];
   logic signed [hxm_pkg::PROD_W-1:0] mul_prod_in [MOTORS];
   logic signed [hxm_pkg::PROD_W-1:0] scale_ext;

   assign scale_ext = $signed(hxm_pkg::PROD_W'(div_quo_ff[DIV_STAGES]));

   always_comb begin
      for (int i = 0; i < MOTORS; i++) begin
         mul_prod_in[i] = hxm_pkg::PROD_W'(div_dem_ff[DIV_STAGES][i]) * scale_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= div_valid_ff[DIV_STAGES];
      end
      mul_tpos_ff <= div_tpos_ff[DIV_STAGES];
      mul_prod_ff <= mul_prod_in;
   end

   // ---------------------------------------------------------------------
   // Saturate: negative products and non-positive thrust give zero, anything past
   // full scale squared clamps there, so the later divide by 1000 lands
   // in 0..1000 with no further clamp.
   // ---------------------------------------------------------------------
   logic                     sat_valid_ff;
   logic [hxm_pkg::SAT_W-1:0] sat_ff [MOTORS];
   logic [hxm_pkg::SAT_W-1:0] sat_in [MOTORS];

   always_comb begin
      for (int i = 0; i < MOTORS; i++) begin
         if (!mul_tpos_ff || mul_prod_ff[i][hxm_pkg::PROD_W-1] || (mul_prod_ff[i] == '0)) begin
            sat_in[i] = '0;
         end else if (mul_prod_ff[i] > hxm_pkg::PROD_W'(hxm_pkg::SAT_MAX)) begin
            sat_in[i] = hxm_pkg::SAT_W'(hxm_pkg::SAT_MAX);
         end else begin
            sat_in[i] = mul_prod_ff[i][hxm_pkg::SAT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_valid_ff <= 1'b0;
      end else begin
         sat_valid_ff <= mul_valid_ff;
      end
      sat_ff <= sat_in;
   end

   // ---------------------------------------------------------------------
   // Output: divide by 1000 through the reciprocal and add the pulse offset.
   // ---------------------------------------------------------------------
   logic                       out_valid_ff;
   logic [hxm_pkg::PWM_W-1:0]   out_pwm_ff [MOTORS];
   logic [hxm_pkg::PWM_W-1:0]   out_pwm_in [MOTORS];
   logic [hxm_pkg::RPROD_W-1:0] recip_prod [MOTORS];

   always_comb begin
      for (int i = 0; i < MOTORS; i++) begin
         recip_prod[i] = hxm_pkg::RPROD_W'(sat_ff[i]) * hxm_pkg::RPROD_W'(hxm_pkg::RECIP);
         out_pwm_in[i] = hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
                       + hxm_pkg::PWM_W'(recip_prod[i][hxm_pkg::RECIP_SHIFT +: hxm_pkg::QUO_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= sat_valid_ff;
      end
      out_pwm_ff <= out_pwm_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_motor_one_pwm   = out_pwm_ff[0];
   assign rsp_motor_two_pwm   = out_pwm_ff[1];
   assign rsp_motor_three_pwm = out_pwm_ff[2];
   assign rsp_motor_four_pwm  = out_pwm_ff[3];
   assign rsp_motor_five_pwm  = out_pwm_ff[4];
   assign rsp_motor_six_pwm   = out_pwm_ff[5];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Every accepted transaction comes out after the fixed pipeline latency.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(hxm_pkg::LATENCY) rsp_valid)
      else $error("accepted transaction did not appear after the pipeline latency");

   // A non-positive thrust command idles all six motors.
   a_idle_thrust : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_thrust_milli[hxm_pkg::CMD_W-1] || (req_thrust_milli == '0)))
      |-> ##(hxm_pkg::LATENCY)
      (rsp_motor_one_pwm == hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && rsp_motor_two_pwm == hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && rsp_motor_three_pwm == hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && rsp_motor_four_pwm == hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && rsp_motor_five_pwm == hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && rsp_motor_six_pwm == hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)))
      else $error("motor pulse not idle for non-positive thrust");

   // The scale never exceeds full scale, since the divisor is floored there.
   a_scale_bound : assert property (@(posedge clock) disable iff (reset)
      div_valid_ff[DIV_STAGES]
      |-> (div_quo_ff[DIV_STAGES] <= hxm_pkg::QUO_W'(hxm_pkg::FULL_SCALE)))
      else $error("divider scale above full scale");

   // Results stay inside the pulse range.
   a_pwm_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (out_pwm_ff[0] >= hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && out_pwm_ff[0] <= hxm_pkg::PWM_W'(hxm_pkg::PWM_MAX)
       && out_pwm_ff[1] >= hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && out_pwm_ff[1] <= hxm_pkg::PWM_W'(hxm_pkg::PWM_MAX)
       && out_pwm_ff[2] >= hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && out_pwm_ff[2] <= hxm_pkg::PWM_W'(hxm_pkg::PWM_MAX)
       && out_pwm_ff[3] >= hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && out_pwm_ff[3] <= hxm_pkg::PWM_W'(hxm_pkg::PWM_MAX)
       && out_pwm_ff[4] >= hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && out_pwm_ff[4] <= hxm_pkg::PWM_W'(hxm_pkg::PWM_MAX)
       && out_pwm_ff[5] >= hxm_pkg::PWM_W'(hxm_pkg::PWM_MIN)
       && out_pwm_ff[5] <= hxm_pkg::PWM_W'(hxm_pkg::PWM_MAX)))
      else $error("motor pulse outside 1000..2000");

endmodule

// ===== bench/hexacopter_x_motor_mixer_tb.sv =====
// Self-checking testbench for the hexacopter-X motor mixer: a directed table
// followed by randomized commands, checked against typed pulses or a mixer model.
// Depends on hxm_pkg and the hexacopter_x_motor_mixer RTL.
module hexacopter_x_motor_mixer_tb;

   localparam int MOTORS     = hxm_pkg::MOTORS;
   localparam int CMD_W      = hxm_pkg::CMD_W;
   localparam int PWM_W      = hxm_pkg::PWM_W;
   localparam int COS30_Q16  = hxm_pkg::COS30_Q16;
   localparam int FULL_SCALE = hxm_pkg::FULL_SCALE;
   localparam int LATENCY    = hxm_pkg::LATENCY;

   typedef logic [MOTORS-1:0][PWM_W-1:0] pulse_set_type;

   typedef struct packed {
      logic signed [CMD_W-1:0] thrust;
      logic signed [CMD_W-1:0] roll;
      logic signed [CMD_W-1:0] pitch;
      logic signed [CMD_W-1:0] yaw;
      logic                    typed;
      pulse_set_type           want;
   } command_row_type;

   localparam logic signed [CMD_W-1:0] CMD_MIN = -(1 << (CMD_W - 1));
   localparam logic signed [CMD_W-1:0] CMD_MAX = (1 << (CMD_W - 1)) - 1;
   localparam pulse_set_type ALL_IDLE = {MOTORS{11'd1000}};
   localparam pulse_set_type ALL_HALF = {MOTORS{11'd1500}};
   localparam pulse_set_type ALL_FULL = {MOTORS{11'd2000}};
   localparam pulse_set_type ALL_LOW1 = {MOTORS{11'd1001}};
   localparam int DIRECTED_ROWS  = 20;
   localparam int RANDOM_COUNT   = 700;
   localparam int STEADY_COUNT   = 150;
   localparam int QUIET_LIMIT    = 500;
   localparam int REPORT_LIMIT   = 10;

   // Rows with typed = 0 are checked against the mixer model instead.
   localparam command_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{0,       0,       0,       0,       1'b1, ALL_IDLE},
      '{CMD_MIN, CMD_MAX, CMD_MIN, CMD_MAX, 1'b1, ALL_IDLE},
      '{-1,      500,     -500,    300,     1'b1, ALL_IDLE},
      '{1,       0,       0,       0,       1'b1, ALL_LOW1},
      '{500,     0,       0,       0,       1'b1, ALL_HALF},
      '{1000,    0,       0,       0,       1'b1, ALL_FULL},
      '{1001,    0,       0,       0,       1'b0, '0},
      '{CMD_MAX, 0,       0,       0,       1'b0, '0},
      '{1000,    CMD_MAX, 0,       0,       1'b0, '0},
      '{1000,    CMD_MIN, 0,       0,       1'b0, '0},
      '{1000,    0,       CMD_MAX, 0,       1'b0, '0},
      '{1000,    0,       CMD_MIN, 0,       1'b0, '0},
      '{1000,    0,       0,       CMD_MAX, 1'b0, '0},
      '{1000,    0,       0,       CMD_MIN, 1'b0, '0},
      '{300,     -1000,   0,       0,       1'b0, '0},
      '{400,     -3,      -7,      1,       1'b0, '0},
      '{600,     1,       1,       -1,      1'b0, '0},
      '{CMD_MAX, CMD_MAX, CMD_MAX, CMD_MAX, 1'b0, '0},
      '{CMD_MAX, CMD_MIN, CMD_MIN, CMD_MIN, 1'b0, '0},
      '{700,     200,     -150,    50,      1'b0, '0}
   };

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [CMD_W-1:0] req_thrust_milli;
   logic signed [CMD_W-1:0] req_roll_milli;
   logic signed [CMD_W-1:0] req_pitch_milli;
   logic signed [CMD_W-1:0] req_yaw_milli;
   logic                    rsp_valid;
   logic [PWM_W-1:0]        rsp_motor_one_pwm;
   logic [PWM_W-1:0]        rsp_motor_two_pwm;
   logic [PWM_W-1:0]        rsp_motor_three_pwm;
   logic [PWM_W-1:0]        rsp_motor_four_pwm;
   logic [PWM_W-1:0]        rsp_motor_five_pwm;
   logic [PWM_W-1:0]        rsp_motor_six_pwm;

   pulse_set_type pending_pulses [$];
   pulse_set_type next_pulses;
   int            error_count;
   int            accepted_count;
   int            result_count;
   int            quiet_cycles;
   int            burst_left;
   int            cut_count;
   int            wide_count;

   hexacopter_x_motor_mixer dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_thrust_milli    (req_thrust_milli),
      .req_roll_milli      (req_roll_milli),
      .req_pitch_milli     (req_pitch_milli),
      .req_yaw_milli       (req_yaw_milli),
      .rsp_valid           (rsp_valid),
      .rsp_motor_one_pwm   (rsp_motor_one_pwm),
      .rsp_motor_two_pwm   (rsp_motor_two_pwm),
      .rsp_motor_three_pwm (rsp_motor_three_pwm),
      .rsp_motor_four_pwm  (rsp_motor_four_pwm),
      .rsp_motor_five_pwm  (rsp_motor_five_pwm),
      .rsp_motor_six_pwm   (rsp_motor_six_pwm)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Mixes one command into six pulse widths; index 0 is motor one.
   function automatic pulse_set_type mix_to_pulses(input logic signed [CMD_W-1:0] thr,
                                                   input logic signed [CMD_W-1:0] rol,
                                                   input logic signed [CMD_W-1:0] pit,
                                                   input logic signed [CMD_W-1:0] yw);
      int t, r, p, y;
      int half_roll, pitch_mag, pitch_k, peak, scale, c;
      int dem [MOTORS];
      pulse_set_type pulses;
      t = thr;
      r = rol;
      p = pit;
      y = yw;
      half_roll = r / 2;
      pitch_mag = (p < 0) ? -p : p;
      pitch_k   = (pitch_mag * COS30_Q16) >> 16;
      if (p < 0) pitch_k = -pitch_k;
      dem[0] = t - r + y;
      dem[1] = t + r - y;
      dem[2] = t + half_roll - pitch_k + y;
      dem[3] = t - half_roll + pitch_k - y;
      dem[4] = t - half_roll - pitch_k - y;
      dem[5] = t + half_roll + pitch_k + y;
      peak = FULL_SCALE;
      for (int i = 0; i < MOTORS; i++) begin
         if (dem[i] > peak) peak = dem[i];
      end
      scale = (peak > FULL_SCALE) ? (FULL_SCALE * FULL_SCALE) / peak : FULL_SCALE;
      for (int i = 0; i < MOTORS; i++) begin
         c = (t > 0) ? (dem[i] * scale) / FULL_SCALE : 0;
         if (c < 0) c = 0;
         if (c > FULL_SCALE) c = FULL_SCALE;
         pulses[i] = PWM_W'(FULL_SCALE + c);
      end
      return pulses;
   endfunction

   function automatic logic signed [CMD_W-1:0] rand_cmd(input int lo, input int hi);
      return CMD_W'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   // Presents one command at the falling edge and holds it until it is taken.
   task automatic send_command(input logic signed [CMD_W-1:0] thr,
                               input logic signed [CMD_W-1:0] rol,
                               input logic signed [CMD_W-1:0] pit,
                               input logic signed [CMD_W-1:0] yw,
                               input pulse_set_type want);
      @(negedge clock);
      start            = 1'b1;
      req_thrust_milli = thr;
      req_roll_milli   = rol;
      req_pitch_milli  = pit;
      req_yaw_milli    = yw;
      next_pulses      = want;
      do @(posedge clock); while (busy);
   endtask

   // Unless steady, counts down a burst and ends it with a random gap; the inputs carry noise while start is low.
   task automatic pace_sender(input bit steady);
      if (!steady) begin
         if (burst_left == 0) begin
            repeat ($urandom_range(1, 8)) begin
               @(negedge clock);
               start            = 1'b0;
               req_thrust_milli = CMD_W'($urandom);
               req_roll_milli   = CMD_W'($urandom);
               req_pitch_milli  = CMD_W'($urandom);
               req_yaw_milli    = CMD_W'($urandom);
            end
            burst_left = $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   always @(posedge clock) begin
      pulse_set_type got;
      pulse_set_type want;
      if (!reset) begin
         if (start && !busy) begin
            pending_pulses.push_back(next_pulses);
            accepted_count++;
         end
         if (rsp_valid) begin
            got = {rsp_motor_six_pwm, rsp_motor_five_pwm, rsp_motor_four_pwm,
                   rsp_motor_three_pwm, rsp_motor_two_pwm, rsp_motor_one_pwm};
            if (pending_pulses.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("Unexpected result at %0t: no transaction outstanding", $time);
            end else begin
               want = pending_pulses.pop_front();
               for (int i = 0; i < MOTORS; i++) begin
                  if (got[i] !== want[i]) begin
                     error_count++;
                     if (error_count <= REPORT_LIMIT)
                        $display("Result %0d motor %0d: expected %0d, got %0d",
                                 result_count, i + 1, want[i], got[i]);
                  end
               end
            end
            result_count++;
         end
         quiet_cycles = ((start && !busy) || rsp_valid) ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      wait (reset === 1'b0);
      while (quiet_cycles < QUIET_LIMIT) @(negedge clock);
      $display("Watchdog expired after %0d quiet cycles", QUIET_LIMIT);
      $display("hexacopter_x_motor_mixer_tb NOT OK");
      $finish;
   end

   initial begin
      logic signed [CMD_W-1:0] thr, rol, pit, yw;
      pulse_set_type want;
      int mode;
      reset            = 1'b1;
      start            = 1'b0;
      req_thrust_milli = '0;
      req_roll_milli   = '0;
      req_pitch_milli  = '0;
      req_yaw_milli    = '0;
      next_pulses      = '0;
      error_count      = 0;
      accepted_count   = 0;
      result_count     = 0;
      quiet_cycles     = 0;
      burst_left       = 0;
      cut_count        = 0;
      wide_count       = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         want = DIRECTED[k].typed ? DIRECTED[k].want
                : mix_to_pulses(DIRECTED[k].thrust, DIRECTED[k].roll,
                                DIRECTED[k].pitch, DIRECTED[k].yaw);
         send_command(DIRECTED[k].thrust, DIRECTED[k].roll,
                      DIRECTED[k].pitch, DIRECTED[k].yaw, want);
         pace_sender(1'b0);
      end

      // The first stretch runs back to back; the rest comes in bursts.
      for (int k = 0; k < RANDOM_COUNT; k++) begin
         mode = $urandom_range(0, 9);
         if (mode <= 5) begin
            thr = rand_cmd(1, 1200);
            rol = rand_cmd(-400, 400);
            pit = rand_cmd(-400, 400);
            yw  = rand_cmd(-300, 300);
         end else if (mode <= 7) begin
            thr = CMD_W'($urandom);
            rol = CMD_W'($urandom);
            pit = CMD_W'($urandom);
            yw  = CMD_W'($urandom);
            wide_count++;
         end else if (mode == 8) begin
            thr = rand_cmd(-4096, 0);
            rol = rand_cmd(-4096, 4095);
            pit = rand_cmd(-4096, 4095);
            yw  = rand_cmd(-4096, 4095);
         end else begin
            thr = rand_cmd(800, 4095);
            rol = rand_cmd(-4096, 4095);
            pit = rand_cmd(-4096, 4095);
            yw  = rand_cmd(-4096, 4095);
         end
         if (thr <= 0) cut_count++;
         send_command(thr, rol, pit, yw, mix_to_pulses(thr, rol, pit, yw));
         pace_sender(k < STEADY_COUNT);
      end

      @(negedge clock);
      start = 1'b0;
      while (pending_pulses.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      if (pending_pulses.size() != 0) error_count++;

      $display("Mixed %0d commands (%0d from the directed table), checked %0d results.",
               accepted_count, DIRECTED_ROWS, result_count);
      $display("Random part: %0d with thrust cut off, %0d over the full 13-bit range.",
               cut_count, wide_count);
      if (error_count == 0) begin
         $display("hexacopter_x_motor_mixer_tb OK");
      end else begin
         $display("%0d mismatches in total", error_count);
         $display("hexacopter_x_motor_mixer_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hxm_pkg.sv
src/hexacopter_x_motor_mixer.sv
bench/hexacopter_x_motor_mixer_tb.sv
